[rtl/dltq_pkg.sv]
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared types, constants and codes for the delta-list timer queue.
// ----------------------------------------------------------------------------
package dltq_pkg;

    // Number of timer tasks, which is also the queue depth.
    localparam int NUM_TASKS = 8;
    // Width of a queue position.
    localparam int IDX_W     = $clog2(NUM_TASKS);
    // Width of a stored task index.
    localparam int TASK_W    = $clog2(NUM_TASKS);
    // Width of the queue fill count, which must be able to hold NUM_TASKS.
    localparam int CNT_W     = $clog2(NUM_TASKS + 1);
    // Width of a delta value.
    localparam int DELTA_W   = 16;
    // Largest delta value, used to saturate merged deltas.
    localparam logic [DELTA_W-1:0] DELTA_MAX = '1;

    // Operation codes of an input transaction.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_ABORT = 2'd2,
        OP_QUERY = 2'd3
    } t_opcode;

    // Per-task status codes.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_DONE = 2'd2
    } t_task_status;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  task_index;
        logic [15:0] delay_us;
        logic        use_callback;
    } t_in_item;

    // Result transaction payload.
    typedef struct packed {
        logic        fired;
        logic [2:0]  fired_task;
        logic        notify_request;
        logic [1:0]  task_status;
        logic        error;
        logic        last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_TICK_DEC,
        CMD_FIRE,
        CMD_ABT_FIND,
        CMD_ABT_SHIFT,
        CMD_ABT_MERGE,
        CMD_INS_INIT,
        CMD_WALK_ADV,
        CMD_WALK_FIX,
        CMD_INS_PUT,
        CMD_REPLY,
        CMD_REPLY_ERR
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       task_ok;
        logic       delay_zero;
        logic       running;
        logic       count_zero;
        logic       count_full;
        logic       walk_end;
        logic       walk_less;
        logic       head_due;
        logic       out_free;
    } t_dp_status;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_TICK_DEC,
        S_FIRE,
        S_ABT_FIND,
        S_ABT_SHIFT,
        S_ABT_MERGE,
        S_INS_INIT,
        S_INS_WALK,
        S_INS_PUT,
        S_REPLY,
        S_REPLY_ERR
    } t_ctrl_state;

    // True when a task index names an existing task.
    function automatic logic task_in_range(input logic [2:0] t);
        return (32'(t) < NUM_TASKS);
    endfunction

endpackage

[rtl/dltq_datapath.sv]
// ----------------------------------------------------------------------------
// dltq_datapath
// Queue storage, per-task status, walk pointer and result register.
// ----------------------------------------------------------------------------
module dltq_datapath import dltq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in_data,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data
);

    logic [TASK_W-1:0]  r_q_task  [NUM_TASKS];
    logic [DELTA_W-1:0] r_q_delta [NUM_TASKS];
    logic [CNT_W-1:0]   r_count;
    t_task_status       r_status  [NUM_TASKS];
    logic [NUM_TASKS-1:0] r_notify;
    logic [CNT_W-1:0]   r_ptr;
    logic [DELTA_W-1:0] r_rem;
    t_in_item           r_cmd_in;
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic [DELTA_W-1:0] rd_delta;
    logic [DELTA_W:0]   merge_sum;
    logic [DELTA_W-1:0] merge_sat;
    logic [CNT_W-1:0]   match_pos;
    logic [TASK_W-1:0]  cur_task;
    logic [TASK_W-1:0]  head_task;
    logic               cur_task_ok;
    t_task_status       cur_status;
    logic               fire_last;

    // The single read port of the queue follows the walk pointer.
    assign rd_delta  = r_q_delta[r_ptr[IDX_W-1:0]];
    assign merge_sum = {1'b0, rd_delta} + {1'b0, r_rem};
    assign merge_sat = merge_sum[DELTA_W] ? DELTA_MAX : merge_sum[DELTA_W-1:0];

    assign cur_task    = r_cmd_in.task_index[TASK_W-1:0];
    assign cur_task_ok = task_in_range(r_cmd_in.task_index);
    assign cur_status  = cur_task_ok ? r_status[cur_task] : ST_IDLE;
    assign head_task   = r_q_task[0];
    // The popped head is the last to fire when nothing with zero delta follows it.
    assign fire_last   = (r_count == CNT_W'(1)) || (r_q_delta[1] != '0);

    // Find the first live queue entry that holds the named task.
    always_comb begin
        match_pos = '0;
        for (int i = NUM_TASKS - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < r_count) && (r_q_task[i] == cur_task)) begin
                match_pos = CNT_W'(i);
            end
        end
    end

    // Status flags for the controller.
    always_comb begin
        o_status.op         = r_cmd_in.opcode;
        o_status.task_ok    = cur_task_ok;
        o_status.delay_zero = (r_cmd_in.delay_us == '0);
        o_status.running    = cur_task_ok && (r_status[cur_task] == ST_RUN);
        o_status.count_zero = (r_count == '0);
        o_status.count_full = (r_count >= CNT_W'(NUM_TASKS));
        o_status.walk_end   = (r_ptr == r_count);
        o_status.walk_less  = (r_rem < rd_delta);
        o_status.head_due   = (r_count != '0) && (r_q_delta[0] == '0);
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    // Control state: fill count, task status, notify enables, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_notify    <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_status[i] <= ST_IDLE;
            end
        end else begin
            // A result stays valid until taken, unless a new one replaces it.
            if (i_cmd inside {CMD_FIRE, CMD_REPLY, CMD_REPLY_ERR}) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd)
                CMD_FIRE: begin
                    r_count             <= r_count - CNT_W'(1);
                    r_status[head_task] <= ST_DONE;
                end
                CMD_ABT_FIND: begin
                    r_status[cur_task] <= ST_IDLE;
                end
                CMD_ABT_SHIFT: begin
                    r_count <= r_count - CNT_W'(1);
                end
                CMD_INS_PUT: begin
                    r_count            <= r_count + CNT_W'(1);
                    r_status[cur_task] <= ST_RUN;
                    r_notify[cur_task] <= r_cmd_in.use_callback;
                end
                default: begin
                end
            endcase
        end
    end

    // Payload: queue entries, walk registers, latched command, result data.
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LATCH: begin
                r_cmd_in <= i_in_data;
            end
            CMD_TICK_DEC: begin
                if (r_q_delta[0] != '0) begin
                    r_q_delta[0] <= r_q_delta[0] - DELTA_W'(1);
                end
            end
            CMD_FIRE: begin
                for (int i = 0; i < NUM_TASKS - 1; i++) begin
                    r_q_delta[i] <= r_q_delta[i+1];
                    r_q_task[i]  <= r_q_task[i+1];
                end
                r_out_data.fired          <= 1'b1;
                r_out_data.fired_task     <= 3'(head_task);
                r_out_data.notify_request <= r_notify[head_task];
                r_out_data.task_status    <= ST_DONE;
                r_out_data.error          <= 1'b0;
                r_out_data.last           <= fire_last;
            end
            CMD_ABT_FIND: begin
                r_ptr <= match_pos;
            end
            CMD_ABT_SHIFT: begin
                // Keep the removed delta so it can be added to its successor.
                r_rem <= rd_delta;
                for (int i = 0; i < NUM_TASKS - 1; i++) begin
                    if (CNT_W'(i) >= r_ptr) begin
                        r_q_delta[i] <= r_q_delta[i+1];
                        r_q_task[i]  <= r_q_task[i+1];
                    end
                end
            end
            CMD_ABT_MERGE: begin
                if (r_ptr < r_count) begin
                    r_q_delta[r_ptr[IDX_W-1:0]] <= merge_sat;
                end
            end
            CMD_INS_INIT: begin
                r_ptr <= '0;
                r_rem <= r_cmd_in.delay_us;
            end
            CMD_WALK_ADV: begin
                r_rem <= r_rem - rd_delta;
                r_ptr <= r_ptr + CNT_W'(1);
            end
            CMD_WALK_FIX: begin
                r_q_delta[r_ptr[IDX_W-1:0]] <= rd_delta - r_rem;
            end
            CMD_INS_PUT: begin
                for (int i = 1; i < NUM_TASKS; i++) begin
                    if (CNT_W'(i) > r_ptr) begin
                        r_q_delta[i] <= r_q_delta[i-1];
                        r_q_task[i]  <= r_q_task[i-1];
                    end
                end
                r_q_delta[r_ptr[IDX_W-1:0]] <= r_rem;
                r_q_task[r_ptr[IDX_W-1:0]]  <= cur_task;
            end
            CMD_REPLY, CMD_REPLY_ERR: begin
                r_out_data.fired          <= 1'b0;
                r_out_data.fired_task     <= r_cmd_in.task_index;
                r_out_data.notify_request <= 1'b0;
                r_out_data.task_status    <= cur_status;
                r_out_data.error          <= (i_cmd == CMD_REPLY_ERR);
                r_out_data.last           <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[rtl/dltq_ctrl.sv]
// ----------------------------------------------------------------------------
// dltq_ctrl
// Sequencer that steps the datapath through tick, start, abort and query.
// ----------------------------------------------------------------------------
module dltq_ctrl import dltq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = CMD_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd   = CMD_LATCH;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_status.op)
                    OP_TICK: begin
                        n_state = i_status.count_zero ? S_IDLE : S_TICK_DEC;
                    end
                    OP_START: begin
                        if (!i_status.task_ok || i_status.delay_zero) begin
                            n_state = S_REPLY_ERR;
                        end else if (i_status.running) begin
                            n_state = S_ABT_FIND;
                        end else begin
                            n_state = S_INS_INIT;
                        end
                    end
                    OP_ABORT: begin
                        n_state = i_status.running ? S_ABT_FIND : S_REPLY;
                    end
                    OP_QUERY: begin
                        n_state = S_REPLY;
                    end
                    default: begin
                        n_state = S_REPLY;
                    end
                endcase
            end
            S_TICK_DEC: begin
                o_cmd   = CMD_TICK_DEC;
                n_state = S_FIRE;
            end
            S_FIRE: begin
                // Pop due entries one at a time as the result register frees up.
                if (!i_status.head_due) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd = CMD_FIRE;
                end
            end
            S_ABT_FIND: begin
                o_cmd   = CMD_ABT_FIND;
                n_state = S_ABT_SHIFT;
            end
            S_ABT_SHIFT: begin
                o_cmd   = CMD_ABT_SHIFT;
                n_state = S_ABT_MERGE;
            end
            S_ABT_MERGE: begin
                o_cmd   = CMD_ABT_MERGE;
                n_state = (i_status.op == OP_START) ? S_INS_INIT : S_REPLY;
            end
            S_INS_INIT: begin
                if (i_status.count_full) begin
                    n_state = S_REPLY_ERR;
                end else begin
                    o_cmd   = CMD_INS_INIT;
                    n_state = S_INS_WALK;
                end
            end
            S_INS_WALK: begin
                // Walk until the tail or the first entry with a larger delta.
                if (i_status.walk_end) begin
                    n_state = S_INS_PUT;
                end else if (i_status.walk_less) begin
                    o_cmd   = CMD_WALK_FIX;
                    n_state = S_INS_PUT;
                end else begin
                    o_cmd = CMD_WALK_ADV;
                end
            end
            S_INS_PUT: begin
                o_cmd   = CMD_INS_PUT;
                n_state = S_REPLY;
            end
            S_REPLY: begin
                if (i_status.out_free) begin
                    o_cmd   = CMD_REPLY;
                    n_state = S_IDLE;
                end
            end
            S_REPLY_ERR: begin
                if (i_status.out_free) begin
                    o_cmd   = CMD_REPLY_ERR;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/delta_list_timer_queue_unit.sv]
// ----------------------------------------------------------------------------
// delta_list_timer_queue_unit
// One-shot timers kept in a deadline-sorted queue of relative delays.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid, o_in_ready, i_in_data) takes one command
//   per transaction: tick, start, abort or query. The output channel
//   (o_out_valid, i_out_ready, o_out_data) returns one result for each
//   start, abort or query, and one result per expiring task on a tick; the
//   final result of a command carries last. A tick that fires nothing
//   returns no result.
//   One command is processed at a time. A start of a running task first
//   removes it from the queue as an abort does, then inserts it anew; the
//   insert walks the queue entry by entry through its single read port (up
//   to NUM_TASKS - 1 entries). A tick decrements the head delta, then fires
//   the due tasks one at a time.
//   The result register decouples the channels: a new command is accepted
//   while a result still waits; processing pauses only when a new result
//   must be written and the previous one is still held by the receiver.
//   Reset (synchronous, active low) empties the queue and sets every task
//   idle with notification disabled.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_unit import dltq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_dp_cmd    cmd;
    t_dp_status dp_status;

    // Sequencer.
    dltq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (cmd)
    );

    // Queue storage and result register.
    dltq_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[rtl/dltq_checker.sv]
// ----------------------------------------------------------------------------
// dltq_checker
// Port-level checks on the result channel of the timer queue.
// ----------------------------------------------------------------------------
module dltq_checker import dltq_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Only expiries raise notifications.
    a_notify_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.notify_request |-> o_out_data.fired)
        else $error("notification on a result that is not an expiry");

    // An expiry always reports the done status and no error.
    a_fired_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.fired |->
            o_out_data.task_status == ST_DONE && !o_out_data.error)
        else $error("expiry without done status");

    // An error is the single, final result of a start.
    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.error |-> o_out_data.last && !o_out_data.fired)
        else $error("error result not final");

endmodule

bind delta_list_timer_queue_unit dltq_checker u_dltq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
